@@ design/assert_macros.svh @@
// Assertion macros shared by the shared-pool stack design.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on clk and skipped while reset is applied.
`define SPMS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check sampled on clk that also holds through reset.
`define SPMS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/spms_pkg.sv @@
// Package for the shared-pool stack design: sizes, codes, word and command types.
// No dependencies; imported by every module of the design.
package spms_pkg;

  // Pool and stack counts
  localparam int POOL_SLOTS = 128;
  localparam int NUM_STACKS = 3;
  localparam int SLOT_W     = $clog2(POOL_SLOTS);
  localparam int HEAD_IDX_W = $clog2(NUM_STACKS);
  localparam int STACK_ID_W = 2;
  localparam int VALUE_W    = 32;
  localparam int STATUS_W   = 2;

  localparam logic [SLOT_W-1:0]     LAST_SLOT    = SLOT_W'(POOL_SLOTS - 1);
  localparam logic [STACK_ID_W-1:0] STACK_ID_MAX = STACK_ID_W'(NUM_STACKS - 1);

  // Operation codes
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

  localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = '1;

  // Input word
  typedef struct packed {
    logic                      mode;
    logic [STACK_ID_W-1:0]     stack_id;
    logic signed [VALUE_W-1:0] push_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [VALUE_W-1:0] pop_value;
    logic [STATUS_W-1:0]       status;
  } out_word_t;

  // Slot pointer with its valid bit (invalid = null)
  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } link_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the input word, read the slot's link and value
    logic commit;   // write back lists and memories, load the result register
  } spms_cmd_t;

endpackage

@@ design/spms_ctrl.sv @@
// Controller for the shared-pool stack: handshakes and two-state sequencer.
// Depends on spms_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spms_ctrl
  import spms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output spms_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Take a word only when idle and the result register is free or draining
  assign in_stall    = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign cmd.capture = in_valid && !in_stall;
  assign cmd.commit  = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.capture) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `SPMS_ASSERT(a_capture_then_commit, cmd.capture |=> cmd.commit, "capture not followed by commit")
  `SPMS_ASSERT(a_commit_has_capture, cmd.commit |-> $past(cmd.capture), "commit without capture")
  `SPMS_ASSERT(a_commit_reg_free, cmd.commit |-> !(out_valid && out_stall), "result overwritten")
  `SPMS_ASSERT(a_out_from_commit, $rose(out_valid) |-> $past(cmd.commit), "result without commit")

endmodule

@@ design/spms_dp.sv @@
// Datapath for the shared-pool stack: head and free-list registers, link and
// value memories, result register. Depends on spms_pkg.
module spms_dp
  import spms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  spms_cmd_t cmd,
  input  in_word_t  in_word,
  output out_word_t out_word
);

  // List state
  logic [SLOT_W-1:0] head_slot_r [NUM_STACKS];
  logic              head_vld_r  [NUM_STACKS];
  logic [SLOT_W-1:0] free_slot_r;
  logic              free_vld_r;
  logic [POOL_SLOTS-1:0] written_r;  // link entry has been written

  // Memories
  link_t                     link_mem  [POOL_SLOTS];
  logic signed [VALUE_W-1:0] value_mem [POOL_SLOTS];

  // Per-word registers
  logic                      op_push_r;
  logic                      err_r;
  logic [HEAD_IDX_W-1:0]     sid_r;
  logic [SLOT_W-1:0]         slot_r;
  logic signed [VALUE_W-1:0] val_r;
  link_t                     link_rd_r;
  logic                      seen_r;
  logic signed [VALUE_W-1:0] value_rd_r;
  out_word_t                 out_word_r;

  // Capture-cycle decode
  logic                  sid_ok;
  logic [HEAD_IDX_W-1:0] sid_idx;
  logic                  is_push;
  logic                  hv_sel;
  logic [SLOT_W-1:0]     hs_sel;
  logic [SLOT_W-1:0]     slot_sel;
  logic                  err_sel;

  assign sid_ok  = (in_word.stack_id <= STACK_ID_MAX);
  assign sid_idx = in_word.stack_id[HEAD_IDX_W-1:0];
  assign is_push = (in_word.mode == MODE_PUSH);
  assign hv_sel  = sid_ok ? head_vld_r[sid_idx] : 1'b0;
  assign hs_sel  = sid_ok ? head_slot_r[sid_idx] : '0;

  always_comb begin
    if (is_push) begin
      slot_sel = free_slot_r;
      err_sel  = !sid_ok || !free_vld_r;
    end else begin
      slot_sel = hs_sel;
      err_sel  = !sid_ok || !hv_sel;
    end
  end

  // Latch the word and read the chosen slot
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_push_r  <= is_push;
      err_r      <= err_sel;
      sid_r      <= sid_idx;
      slot_r     <= slot_sel;
      val_r      <= in_word.push_value;
      link_rd_r  <= link_mem[slot_sel];
      value_rd_r <= value_mem[slot_sel];
      seen_r     <= written_r[slot_sel];
    end
  end

  // Link of the slot: an unwritten entry still has its reset chain to the next slot
  link_t slot_link;
  always_comb begin
    if (seen_r) begin
      slot_link = link_rd_r;
    end else begin
      slot_link.slot  = SLOT_W'(slot_r + 1'b1);
      slot_link.valid = (slot_r != LAST_SLOT);
    end
  end

  logic do_write;
  assign do_write = cmd.commit && !err_r;

  // Head and free-list update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STACKS; i++) begin
        head_slot_r[i] <= '0;
        head_vld_r[i]  <= 1'b0;
      end
      free_slot_r <= '0;
      free_vld_r  <= 1'b1;
      written_r   <= '0;
    end else if (do_write) begin
      written_r[slot_r] <= 1'b1;
      if (op_push_r) begin
        free_slot_r        <= slot_link.slot;
        free_vld_r         <= slot_link.valid;
        head_slot_r[sid_r] <= slot_r;
        head_vld_r[sid_r]  <= 1'b1;
      end else begin
        head_slot_r[sid_r] <= slot_link.slot;
        head_vld_r[sid_r]  <= slot_link.valid;
        free_slot_r        <= slot_r;
        free_vld_r         <= 1'b1;
      end
    end
  end

  // Memory write-back
  always_ff @(posedge clk) begin
    if (do_write) begin
      if (op_push_r) begin
        link_mem[slot_r]  <= '{valid: head_vld_r[sid_r], slot: head_slot_r[sid_r]};
        value_mem[slot_r] <= val_r;
      end else begin
        link_mem[slot_r] <= '{valid: free_vld_r, slot: free_slot_r};
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_push_r) begin
        out_word_r.pop_value <= '0;
        out_word_r.status    <= err_r ? STAT_OVERFLOW : STAT_OK;
      end else if (err_r) begin
        out_word_r.pop_value <= UNDERFLOW_VALUE;
        out_word_r.status    <= STAT_UNDERFLOW;
      end else begin
        out_word_r.pop_value <= value_rd_r;
        out_word_r.status    <= STAT_OK;
      end
    end
  end

  assign out_word = out_word_r;

endmodule

@@ design/shared_pool_multi_stack.sv @@
// Channel   Ports                         Word
// input     in_valid, in_stall, in_word   mode, stack_id, push_value
// result    out_valid, out_stall, out_word pop_value, status
//
// Each word is handled in a capture step, which reads the slot's link and value memories,
// and then a commit step, which writes the lists back and loads the result register.
// Reset is synchronous; afterwards the free list holds every slot in order and
// all stacks are empty. No clearing pass is needed.
// A stalled result holds the input off only while it is still waiting.
// Depends on spms_pkg, spms_ctrl and spms_dp.
module shared_pool_multi_stack
  import spms_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  spms_cmd_t cmd;

  // Sequencer and handshakes
  spms_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Lists, memories and result
  spms_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .out_word (out_word)
  );

endmodule
